// File: rtl/mse_pkg.sv
`timescale 1ns / 1ps

package mse_pkg;

    localparam int WORD_W = 32;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     last_item;
    } load_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflowed;
    } result_item_t;

endpackage

// File: rtl/mse_ram.sv
`timescale 1ns / 1ps

module mse_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [mse_pkg::WORD_W-1:0]    wdata,
    input  logic [AW-1:0]                 raddr_a,
    input  logic [AW-1:0]                 raddr_b,
    output logic [mse_pkg::WORD_W-1:0]    rdata_a,
    output logic [mse_pkg::WORD_W-1:0]    rdata_b
);
    import mse_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: rtl/merge_sort_engine.sv
`timescale 1ns / 1ps

// Sorts a set of up to DEPTH signed Q16.16 values in ascending order, with
// equal values kept in arrival order. Values are loaded one per cycle into a
// RAM bank until the item marked last_item; further values beyond DEPTH are
// dropped and every result of that set reports overflowed. Sorting then runs
// bottom-up merge passes that ping-pong between two RAM banks, each bank with
// two read ports, so one element is merged per cycle: a set of n values takes
// ceil(log2 n) passes. The sorted values then stream out one per cycle while
// result_stall is low, with last_out on the final one. No new item is taken
// between the closing item and the final result of that set.
module merge_sort_engine #(
    parameter int DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    output logic                  load_stall,
    input  mse_pkg::load_item_t   load_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output mse_pkg::result_item_t result_item
);
    import mse_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;

    typedef enum logic [1:0] {
        LOAD,
        PASS,
        MERGE,
        DRAIN
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic           sel_reg, sel_next;
    logic [WW-1:0]  w_reg, w_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [CW-1:0]  mid_reg, mid_next;
    logic [CW-1:0]  hi_reg, hi_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  o_reg, o_next;
    logic           valid_reg, valid_next;

    logic              load_accept;
    logic              room;
    logic              result_accept;
    logic              take_left;
    logic [WORD_W-1:0] src_a, src_b, merge_data;
    logic [WORD_W-1:0] r0_a, r0_b, r1_a, r1_b;
    logic [SW-1:0]     n_ext, mid_sum, hi_sum, w2;
    logic [AW-1:0]     raddr_a, raddr_b;
    logic              we0, we1;
    logic [AW-1:0]     waddr0;
    logic [WORD_W-1:0] wdata0;

    assign load_stall    = (state_reg != LOAD);
    assign load_accept   = load_valid && !load_stall;
    assign result_valid  = valid_reg;
    assign result_accept = valid_reg && !result_stall;
    assign room          = (count_reg < CW'(DEPTH));

    assign src_a = sel_reg ? r1_a : r0_a;
    assign src_b = sel_reg ? r1_b : r0_b;

    // Left run wins ties, which keeps the sort stable.
    assign take_left  = (i_reg < mid_reg) &&
                        ((j_reg >= hi_reg) || ($signed(src_a) <= $signed(src_b)));
    assign merge_data = take_left ? src_a : src_b;

    assign n_ext   = SW'(count_reg);
    assign w2      = {w_reg, 1'b0};
    assign mid_sum = SW'(hi_reg) + SW'(w_reg);
    assign hi_sum  = SW'(hi_reg) + w2;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        sel_next   = sel_reg;
        w_next     = w_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        k_next     = k_reg;
        o_next     = o_reg;
        valid_next = valid_reg;
        case (state_reg)
            LOAD:
            begin
                if (load_accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (load_item.last_item)
                    begin
                        w_next     = WW'(1);
                        state_next = PASS;
                    end
                end
            end
            PASS:
            begin
                if (w_reg >= WW'(count_reg))
                begin
                    o_next     = '0;
                    valid_next = 1'b1;
                    state_next = DRAIN;
                end
                else
                begin
                    i_next     = '0;
                    k_next     = '0;
                    mid_next   = w_reg[CW-1:0];
                    j_next     = w_reg[CW-1:0];
                    hi_next    = (w2 > n_ext) ? count_reg : w2[CW-1:0];
                    state_next = MERGE;
                end
            end
            MERGE:
            begin
                if (take_left)
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
                k_next = k_reg + CW'(1);
                if ((k_reg + CW'(1)) == hi_reg)
                begin
                    if (hi_reg == count_reg)
                    begin
                        sel_next   = !sel_reg;
                        w_next     = {w_reg[WW-2:0], 1'b0};
                        state_next = PASS;
                    end
                    else
                    begin
                        i_next   = hi_reg;
                        mid_next = (mid_sum > n_ext) ? count_reg : mid_sum[CW-1:0];
                        j_next   = (mid_sum > n_ext) ? count_reg : mid_sum[CW-1:0];
                        hi_next  = (hi_sum > n_ext) ? count_reg : hi_sum[CW-1:0];
                    end
                end
            end
            DRAIN:
            begin
                if (result_accept)
                begin
                    if ((o_reg + CW'(1)) == count_reg)
                    begin
                        valid_next = 1'b0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        sel_next   = 1'b0;
                        state_next = LOAD;
                    end
                    else
                    begin
                        o_next = o_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sel_reg   <= 1'b0;
            w_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            k_reg     <= '0;
            o_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            sel_reg   <= sel_next;
            w_reg     <= w_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            k_reg     <= k_next;
            o_reg     <= o_next;
            valid_reg <= valid_next;
        end
    end

    // Reads are issued at the next pointer values, so the read data lines up
    // with the pointer registers in the following cycle.
    assign raddr_a = (state_next == DRAIN) ? o_next[AW-1:0] : i_next[AW-1:0];
    assign raddr_b = j_next[AW-1:0];

    assign we0    = (load_accept && room) || ((state_reg == MERGE) && sel_reg);
    assign waddr0 = (state_reg == MERGE) ? k_reg[AW-1:0] : count_reg[AW-1:0];
    assign wdata0 = (state_reg == MERGE) ? merge_data : load_item.value;
    assign we1    = (state_reg == MERGE) && !sel_reg;

    mse_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bank0 (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr0),
        .wdata   (wdata0),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (r0_a),
        .rdata_b (r0_b)
    );

    mse_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bank1 (
        .clk     (clk),
        .we      (we1),
        .waddr   (k_reg[AW-1:0]),
        .wdata   (merge_data),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (r1_a),
        .rdata_b (r1_b)
    );

    assign result_item.sorted_value = src_a;
    assign result_item.last_out     = ((o_reg + CW'(1)) == count_reg);
    assign result_item.overflowed   = ovf_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import mse_pkg::*;

    localparam int DEPTH = 64;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         load_valid = 1'b0;
    logic         load_stall;
    load_item_t   load_item = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result_item;

    // Values of the open set, kept in ascending order as they arrive.
    logic signed [WORD_W-1:0] sorted_held[$];
    bit                       held_dropped;
    result_item_t             expected_results[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;

    merge_sort_engine #(
        .DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .load_valid(load_valid),
        .load_stall(load_stall),
        .load_item(load_item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_item(result_item)
    );

    always #4 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("FAIL merge_sort_engine");
        $finish;
    end

    // Insert each accepted value within DEPTH behind any equal ones; on the closing
    // item the held set is turned into the expected results.
    task automatic predict_load(input logic signed [WORD_W-1:0] v, input logic last);
        int pos;
        result_item_t r;
        if (sorted_held.size() < DEPTH)
        begin
            pos = sorted_held.size();
            for (int i = 0; i < sorted_held.size(); i++)
            begin
                if (sorted_held[i] > v)
                begin
                    pos = i;
                    break;
                end
            end
            sorted_held.insert(pos, v);
        end
        else
        begin
            held_dropped = 1'b1;
        end
        if (last)
        begin
            for (int i = 0; i < sorted_held.size(); i++)
            begin
                r.sorted_value = sorted_held[i];
                r.last_out     = (i == sorted_held.size() - 1);
                r.overflowed   = held_dropped;
                expected_results.push_back(r);
            end
            sorted_held.delete();
            held_dropped = 1'b0;
        end
    endtask

    task automatic send_item(input logic signed [WORD_W-1:0] v, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            load_valid <= 1'b0;
            @(posedge clk);
        end
        load_valid <= 1'b1;
        load_item.value <= v;
        load_item.last_item <= last;
        do
            @(posedge clk);
        while (load_stall);
        predict_load(v, last);
    endtask

    task automatic wait_drain();
        load_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        result_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value %0d",
                    result_item.sorted_value));
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_item.sorted_value !== want.sorted_value)
                    report_mismatch($sformatf("sorted_value %0d, expected %0d",
                        result_item.sorted_value, want.sorted_value));
                if (result_item.last_out !== want.last_out)
                    report_mismatch($sformatf("last_out %b, expected %b",
                        result_item.last_out, want.last_out));
                if (result_item.overflowed !== want.overflowed)
                    report_mismatch($sformatf("overflowed %b, expected %b",
                        result_item.overflowed, want.overflowed));
            end
        end
    end

    function automatic logic signed [WORD_W-1:0] random_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return $urandom;
        else if (pick < 80)
            return (int'($urandom_range(4)) - 2) <<< 16;
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic test_single_value();
        send_item(32'h7FFF_FFFF, 1'b1);
        wait_drain();
    endtask

    task automatic test_extreme_values();
        logic signed [WORD_W-1:0] vals[7] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
            32'hFFFF_FFFF, 32'h1, 32'h0001_0000, 32'hFFFF_0000};
        foreach (vals[i])
            send_item(vals[i], i == 6);
        wait_drain();
    endtask

    task automatic test_equal_values();
        logic signed [WORD_W-1:0] vals[6] = '{32'h5, 32'h5, -32'sh5, 32'h5, -32'sh5,
            32'h5};
        foreach (vals[i])
            send_item(vals[i], i == 5);
        wait_drain();
    endtask

    // Exactly DEPTH values, closing item included: a full store, no drop.
    task automatic test_full_store();
        for (int i = 0; i < DEPTH; i++)
            send_item($urandom, i == DEPTH - 1);
        wait_drain();
    endtask

    // Two values beyond capacity, the closing one among the dropped.
    task automatic test_overflow();
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(random_value(), i == DEPTH + 1);
        wait_drain();
    endtask

    task automatic test_random_sets(input int idle, input int stall, input int n_items);
        int sent;
        int set_size;
        int pick;
        idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                set_size = $urandom_range(1, 8);
            else if (pick < 95)
                set_size = $urandom_range(9, 24);
            else
                set_size = $urandom_range(DEPTH - 4, DEPTH + 4);
            // The last set of a phase is cut short to keep the phase's length.
            if (set_size > n_items - sent)
                set_size = n_items - sent;
            for (int i = 0; i < set_size; i++)
                send_item(random_value(), i == set_size - 1);
            sent += set_size;
        end
        wait_drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_single_value();
        test_extreme_values();
        test_equal_values();
        test_full_store();
        test_overflow();

        test_random_sets(0, 0, 9);
        test_random_sets(49, 0, 9);
        test_random_sets(0, 49, 9);
        test_random_sets(28, 28, 9);

        if (mismatch_count == 0)
            $display("PASS merge_sort_engine");
        else
            $display("FAIL merge_sort_engine");
        $finish;
    end

endmodule
